[rtl/tkhcl_pkg.sv]
package tkhcl_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int TAG_W       = 32;
    localparam int COST_W      = 64;
    localparam int POS_W       = 4;
    localparam int FILL_W      = 5;
    localparam int SIZE_W      = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [TAG_W-1:0]  item_tag;
        logic [COST_W-1:0] item_cost;
    } cmd_t;

    typedef struct packed {
        logic              accepted;
        logic [POS_W-1:0]  position;
        logic              entry_valid;
        logic [TAG_W-1:0]  entry_tag;
        logic [COST_W-1:0] entry_cost;
        logic [FILL_W-1:0] fill_count;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [COST_W-1:0] cost;
    } entry_t;

    typedef struct packed {
        logic load_en;
        logic rotate;
    } cell_ctl_t;

endpackage

[rtl/tkhcl_cell.sv]
module tkhcl_cell (
    input  logic                clk,
    input  tkhcl_pkg::cell_ctl_t ctl,
    input  logic                occupied,
    input  tkhcl_pkg::entry_t   new_entry,
    input  tkhcl_pkg::entry_t   left_entry,
    input  tkhcl_pkg::entry_t   right_entry,
    input  logic                left_ge,
    output tkhcl_pkg::entry_t   entry,
    output logic                ge,
    output logic                take_new
);
    import tkhcl_pkg::*;

    entry_t entry_reg;

    // an occupied slot whose cost is at least the new one stays ahead of it
    assign ge       = occupied && (entry_reg.cost >= new_entry.cost);
    assign take_new = !ge && left_ge;
    assign entry    = entry_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.rotate)
        begin
            entry_reg <= right_entry;
        end
        else if (ctl.load_en && !ge)
        begin
            entry_reg <= take_new ? new_entry : left_entry;
        end
    end

endmodule

[rtl/top_k_highest_cost_list.sv]
// Channel   Direction  Handshake                      Payload
// command   in         start / busy                   cmd (cmd_t)
// result    out        strobe, one cycle, no stall    result (result_t)
// config    in         cfg_valid / cfg_ready          cfg_data (list size)
//
// On an insert every slot compares its cost with the new one at once, and its
// single result shows on the cycle after the transfer.
// A dump rotates the whole ring of MAX_ENTRIES slots past slot 0, so busy
// stays high until the ring has made a full turn; the first result is
// registered from slot 0 once dump_reg is set, then one a cycle. An empty-list
// dump answers like an insert. Config is held off while a dump is rotating.
// Reset empties the list and sets the list size to 1; no clearing pass.
// The receiver cannot stall: each result is on the ports for one cycle only.
module top_k_highest_cost_list (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  tkhcl_pkg::cmd_t                cmd,
    output logic                           strobe,
    output tkhcl_pkg::result_t             result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tkhcl_pkg::SIZE_W-1:0]   cfg_data
);
    import tkhcl_pkg::*;

    logic [SIZE_W-1:0] list_size_reg;
    logic [CNT_W-1:0]  held_reg;
    logic [CNT_W-1:0]  held_next;
    logic              dump_reg;
    logic [IDX_W-1:0]  cnt_reg;
    logic              strobe_reg;
    result_t           result_reg;

    logic [CNT_W-1:0]  size_eff;
    logic              cmd_xfer;
    logic              cfg_xfer;
    logic              ins_xfer;
    logic              ins_ok;
    logic              any_new;
    logic [IDX_W-1:0]  ins_pos;
    cell_ctl_t         ctl;
    entry_t            new_entry;

    entry_t                 entries  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] ge;
    logic [MAX_ENTRIES-1:0] take_new;
    logic [MAX_ENTRIES-1:0] occupied;

    assign busy      = dump_reg;
    assign cfg_ready = !dump_reg;
    assign cmd_xfer  = start && !busy;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign ins_xfer  = cmd_xfer && (cmd.operation == OP_INSERT);

    assign size_eff = (CNT_W'(list_size_reg) > CNT_W'(MAX_ENTRIES))
                    ? CNT_W'(MAX_ENTRIES) : CNT_W'(list_size_reg);

    assign new_entry.tag  = cmd.item_tag;
    assign new_entry.cost = cmd.item_cost;

    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            occupied[i] = CNT_W'(i) < held_reg;
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++)
        begin : g_cell
            tkhcl_cell u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .occupied    (occupied[g]),
                .new_entry   (new_entry),
                .left_entry  (entries[(g + MAX_ENTRIES - 1) % MAX_ENTRIES]),
                .right_entry (entries[(g + 1) % MAX_ENTRIES]),
                .left_ge     ((g == 0) ? 1'b1 : ge[(g + MAX_ENTRIES - 1) % MAX_ENTRIES]),
                .entry       (entries[g]),
                .ge          (ge[g]),
                .take_new    (take_new[g])
            );
        end
    endgenerate

    // at most one slot takes the new item: the first one that is empty or below its cost
    always_comb
    begin
        ins_pos = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (take_new[i])
            begin
                ins_pos = ins_pos | IDX_W'(i);
            end
        end
    end

    assign any_new = |take_new;
    assign ins_ok  = any_new && (CNT_W'(ins_pos) < size_eff);

    assign ctl.load_en = ins_xfer && ins_ok;
    assign ctl.rotate  = dump_reg;

    always_comb
    begin
        held_next = held_reg;
        if (cfg_xfer)
        begin
            held_next = '0;
        end
        else if (ins_xfer && ins_ok && (held_reg < size_eff))
        begin
            held_next = held_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_size_reg <= SIZE_W'(1);
            held_reg      <= '0;
            dump_reg      <= 1'b0;
            cnt_reg       <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            held_reg   <= held_next;
            strobe_reg <= 1'b0;
            if (cfg_xfer)
            begin
                list_size_reg <= cfg_data;
            end
            if (dump_reg)
            begin
                // advance the ring; it is back in order after a full turn
                strobe_reg <= CNT_W'(cnt_reg) < held_reg;
                cnt_reg    <= cnt_reg + IDX_W'(1);
                if (cnt_reg == IDX_W'(MAX_ENTRIES - 1))
                begin
                    dump_reg <= 1'b0;
                end
            end
            else if (cmd_xfer)
            begin
                if (cmd.operation == OP_DUMP)
                begin
                    cnt_reg <= '0;
                    if (held_reg == '0)
                    begin
                        strobe_reg <= 1'b1;
                    end
                    else
                    begin
                        dump_reg <= 1'b1;
                    end
                end
                else
                begin
                    strobe_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dump_reg)
        begin
            result_reg.accepted    <= 1'b0;
            result_reg.position    <= POS_W'(cnt_reg);
            result_reg.entry_valid <= 1'b1;
            result_reg.entry_tag   <= entries[0].tag;
            result_reg.entry_cost  <= entries[0].cost;
            result_reg.fill_count  <= FILL_W'(held_reg);
            result_reg.last        <= (CNT_W'(cnt_reg) + CNT_W'(1)) == held_reg;
        end
        else
        begin
            result_reg.accepted    <= ins_ok && (cmd.operation == OP_INSERT);
            result_reg.position    <= (ins_ok && (cmd.operation == OP_INSERT))
                                    ? POS_W'(ins_pos) : '0;
            result_reg.entry_valid <= 1'b0;
            result_reg.entry_tag   <= '0;
            result_reg.entry_cost  <= '0;
            result_reg.fill_count  <= FILL_W'(held_next);
            result_reg.last        <= 1'b1;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    a_cfg_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_xfer |=> held_reg == '0)
        else $error("list not emptied by size write");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= size_eff)
        else $error("fill count above list size");

    a_acc_fill: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.accepted |-> result.fill_count != '0)
        else $error("accepted insert with empty list");

    a_dump_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.entry_valid && result.last
            |-> result.position == POS_W'(result.fill_count - FILL_W'(1)))
        else $error("dump ended at wrong slot");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import tkhcl_pkg::*;

    // Tracks the expected contents of the ranked list and the results still owed by the block.
    class cost_rank_board;
        logic [COST_W-1:0] cost_at [MAX_ENTRIES];
        logic [TAG_W-1:0]  tag_at  [MAX_ENTRIES];
        logic [SIZE_W-1:0] size_reg;
        int unsigned       held;
        result_t           due_results [$];
        int unsigned       failures;

        function new();
            size_reg = SIZE_W'(1);
            held     = 0;
            failures = 0;
        endfunction

        // A size write also empties the list.
        function void resize(logic [SIZE_W-1:0] v);
            size_reg = v;
            held     = 0;
        endfunction

        function void take_command(cmd_t c);
            int unsigned cap;
            int unsigned slot;
            result_t     r;
            cap    = (size_reg > MAX_ENTRIES) ? MAX_ENTRIES : size_reg;
            r      = '0;
            r.last = 1'b1;
            if (c.operation == OP_INSERT)
            begin
                if (cap != 0 && (held < cap || cost_at[cap-1] < c.item_cost))
                begin
                    if (held < cap)
                    begin
                        slot = held;
                        held++;
                    end
                    else
                    begin
                        slot = cap - 1;
                    end
                    // Shift cheaper entries down; equal costs keep their place ahead.
                    while (slot > 0 && cost_at[slot-1] < c.item_cost)
                    begin
                        cost_at[slot] = cost_at[slot-1];
                        tag_at[slot]  = tag_at[slot-1];
                        slot--;
                    end
                    cost_at[slot] = c.item_cost;
                    tag_at[slot]  = c.item_tag;
                    r.accepted    = 1'b1;
                    r.position    = POS_W'(slot);
                end
                r.fill_count = FILL_W'(held);
                due_results.push_back(r);
            end
            else if (held == 0)
            begin
                due_results.push_back(r);
            end
            else
            begin
                for (int k = 0; k < held; k++)
                begin
                    r.position    = POS_W'(k);
                    r.entry_valid = 1'b1;
                    r.entry_tag   = tag_at[k];
                    r.entry_cost  = cost_at[k];
                    r.fill_count  = FILL_W'(held);
                    r.last        = (k == held - 1);
                    due_results.push_back(r);
                end
            end
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due_results.size() == 0)
            begin
                $error("result with no transfer outstanding: %0h", got);
                failures++;
                return;
            end
            want = due_results.pop_front();
            check_field("accepted", 64'(want.accepted), 64'(got.accepted));
            check_field("position", 64'(want.position), 64'(got.position));
            check_field("entry_valid", 64'(want.entry_valid), 64'(got.entry_valid));
            check_field("entry_tag", 64'(want.entry_tag), 64'(got.entry_tag));
            check_field("entry_cost", want.entry_cost, got.entry_cost);
            check_field("fill_count", 64'(want.fill_count), 64'(got.fill_count));
            check_field("last", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    cmd_t              cmd       = '0;
    logic              strobe;
    result_t           result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [SIZE_W-1:0] cfg_data  = '0;

    logic cmd_taken = 1'b0;
    logic cfg_taken = 1'b0;
    logic busy_now  = 1'b1;

    cost_rank_board board = new();

    top_k_highest_cost_list dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .strobe    (strobe),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Sample mid-cycle: inputs and outputs only move at the rising edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            cmd_taken = start && !busy;
            cfg_taken = cfg_valid && cfg_ready;
            busy_now  = busy;
            if (cfg_taken)
                board.resize(cfg_data);
            if (cmd_taken)
                board.take_command(cmd);
            if (strobe)
                board.check_result(result);
        end
        else
        begin
            cmd_taken = 1'b0;
            cfg_taken = 1'b0;
            busy_now  = 1'b1;
        end
    end

    function automatic cmd_t mk_cmd(logic op, logic [TAG_W-1:0] tag, logic [COST_W-1:0] cost);
        cmd_t c;
        c.operation = op;
        c.item_tag  = tag;
        c.item_cost = cost;
        return c;
    endfunction

    function automatic cmd_t random_cmd();
        logic [COST_W-1:0] cost;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: cost = COST_W'($urandom_range(0, 15));
            4:          cost = '0;
            5:          cost = '1;
            6:          cost = '1 - COST_W'($urandom_range(0, 3));
            default:    cost = {$urandom, $urandom};
        endcase
        return mk_cmd(($urandom_range(0, 7) == 0) ? OP_DUMP : OP_INSERT, $urandom, cost);
    endfunction

    // Leave start high on return so back-to-back transfers need no second assignment.
    task automatic issue(cmd_t c);
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (!cmd_taken) @(posedge clk);
    endtask

    task automatic pause_sender(int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (board.due_results.size() != 0) @(posedge clk);
    endtask

    // Hold off until a dump has finished rotating the ring as well.
    task automatic settle_list();
        drain_results();
        while (busy_now) @(posedge clk);
        repeat (MAX_ENTRIES + 4) @(posedge clk);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_taken) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [SIZE_W-1:0] phase_size [9];
        int unsigned       idle_pct;
        phase_size = '{16, 3, 0, 31, 1, 17, 5, 2, 0};
        phase_size[8] = SIZE_W'($urandom_range(0, 31));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // List size of one straight from reset
        issue(mk_cmd(OP_DUMP, '0, '0));
        issue(mk_cmd(OP_INSERT, '0, '0));
        issue(mk_cmd(OP_INSERT, '1, '0));
        issue(mk_cmd(OP_INSERT, '1, '1));
        issue(mk_cmd(OP_DUMP, '0, '0));

        // Zero size rejects everything
        settle_list();
        write_size(SIZE_W'(0));
        issue(mk_cmd(OP_INSERT, '1, '1));
        issue(mk_cmd(OP_DUMP, '1, '1));

        // Ties, full-list rejection on an equal cost, eviction of the last entry
        settle_list();
        write_size(SIZE_W'(3));
        issue(mk_cmd(OP_INSERT, 32'h0000_00a1, 64'd5));
        issue(mk_cmd(OP_INSERT, 32'h0000_00b2, 64'd5));
        issue(mk_cmd(OP_INSERT, 32'h0000_00c3, 64'd7));
        issue(mk_cmd(OP_INSERT, 32'h0000_00d4, 64'd5));
        issue(mk_cmd(OP_INSERT, 32'h0000_00e5, 64'd6));
        issue(mk_cmd(OP_DUMP, '0, '0));

        for (int ph = 0; ph < 9; ph++)
        begin
            settle_list();
            write_size(phase_size[ph]);
            idle_pct = (ph < 3) ? 18 : (ph < 6) ? 62 : 0;
            for (int i = 0; i < 45; i++)
            begin
                if (i == 22)
                    drain_results();
                else if ($urandom_range(0, 99) < idle_pct)
                    pause_sender($urandom_range(1, 4));
                issue(random_cmd());
            end
        end

        settle_list();
        if (board.failures == 0 && board.due_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
